@@ rtl/core/fdtd_pkg.sv @@
package fdtd_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int MAX_PML   = 64;
    localparam int FRAC_BITS = 24;

    localparam int IDX_W   = 11;
    localparam int DATA_W  = 32;
    localparam int CELL_W  = $clog2(MAX_CELLS + 1);
    localparam int PML_AW  = $clog2(MAX_PML);
    localparam int OP_W    = 34;
    localparam int PROD_W  = 2 * OP_W;
    localparam int SUM_W   = DATA_W + 2;
    localparam int DVS_W   = 33;
    localparam int DVD_W   = 2 * FRAC_BITS + 2;
    localparam int DCNT_W  = $clog2(DVD_W + 1);

    localparam int COURANT_W = 25;
    localparam int NCELL_W   = 11;
    localparam int PCELL_W   = 7;
    localparam int BLOCH_W   = 26;
    localparam int CFG_W     = 26;
    localparam int CFG_AW    = 3;

    localparam logic [CFG_AW-1:0] CFG_COURANT = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_NCELL   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PML     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_MODE    = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_COS     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SIN     = 3'd5;

    localparam logic [2:0] FN_WE    = 3'd0;
    localparam logic [2:0] FN_WH    = 3'd1;
    localparam logic [2:0] FN_WINV  = 3'd2;
    localparam logic [2:0] FN_WHP   = 3'd3;
    localparam logic [2:0] FN_WEP   = 3'd4;
    localparam logic [2:0] FN_STEP  = 3'd5;
    localparam logic [2:0] FN_RE    = 3'd6;
    localparam logic [2:0] FN_RH    = 3'd7;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] K_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] K_MIN = ~K_MAX;
    localparam logic signed [OP_W-1:0] DEN_BASE = OP_W'(1) <<< (FRAC_BITS + 1);
    localparam logic [DVD_W-1:0] NUM_BASE = DVD_W'(1) << (2 * FRAC_BITS + 1);

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } rs_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    function automatic rs_t sat_to32(input logic signed [PROD_W-1:0] v);
        rs_t r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > SAT_MAX) begin
            r.val = K_MAX;
            r.sat = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = K_MIN;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // Round half up, then saturate to 32 bits.
    function automatic rs_t rnd_sat(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + RND_HALF) >>> FRAC_BITS;
        return sat_to32(t);
    endfunction

endpackage

@@ rtl/core/fdtd_div.sv @@
module fdtd_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  fdtd_pkg::div_req_t             req,
    output logic                           done,
    output logic [fdtd_pkg::DVD_W-1:0]     quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fdtd_pkg::DCNT_W-1:0]   cnt_reg;
    logic [fdtd_pkg::DVS_W-1:0]    rem_reg;
    logic [fdtd_pkg::DVS_W-1:0]    dvs_reg;
    logic [fdtd_pkg::DVD_W-1:0]    quo_reg;
    logic [fdtd_pkg::DVS_W:0]      rem_sh;
    logic [fdtd_pkg::DVS_W+1:0]    trial;
    logic                          ge;

    assign rem_sh = {rem_reg, quo_reg[fdtd_pkg::DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = !trial[fdtd_pkg::DVS_W+1];

    // Restoring division, one quotient bit per cycle; dividend bits shift out
    // of quo_reg as quotient bits shift in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= fdtd_pkg::DCNT_W'(fdtd_pkg::DVD_W);
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? trial[fdtd_pkg::DVS_W-1:0] : rem_sh[fdtd_pkg::DVS_W-1:0];
                quo_reg <= {quo_reg[fdtd_pkg::DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == fdtd_pkg::DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/fdtd_1d_yee_field_step_unit.sv @@
// One-dimensional complex Yee-grid engine with PML. Each beat on the input
// side gives exactly one result beat. After reset the field memories are
// zeroed by a clearing pass over all MAX_CELLS+1 (1025) addresses during
// which no beat is taken. A write, and any access with an index out of range,
// is answered in the cycle after its beat, and the next beat may follow at
// once if the receiver takes that result; a read passes through S_IORD and
// S_IOCP before the next beat is taken. A step runs every grid point through
// one shared multiplier under a sequencer; each PML point also waits on the
// serial divider that forms the PML factor, and in periodic mode the ends get
// a further pass through the Bloch states S_B0 to S_BU. The user must write
// configuration only while the block is idle; the block itself does not
// enforce this.
module fdtd_1d_yee_field_step_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [79:0]                   s_tdata,  // index, value_re, value_im, zero pad
    input  logic [2:0]                    s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // data_re, data_im
    output logic [1:0]                    m_tuser,  // status
    input  logic                          cfg_wen,
    input  logic [fdtd_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [fdtd_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int DW = fdtd_pkg::DATA_W;
    localparam int CW = fdtd_pkg::CELL_W;
    localparam int PW = fdtd_pkg::PML_AW;
    localparam int DEPTH = fdtd_pkg::MAX_CELLS + 1;

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_IORD = 5'd2;
    localparam logic [4:0] S_IOCP = 5'd3;
    localparam logic [4:0] S_RD0  = 5'd4;
    localparam logic [4:0] S_RD1  = 5'd5;
    localparam logic [4:0] S_RD2  = 5'd6;
    localparam logic [4:0] S_M0   = 5'd7;
    localparam logic [4:0] S_M0W  = 5'd8;
    localparam logic [4:0] S_M1   = 5'd9;
    localparam logic [4:0] S_M1W  = 5'd10;
    localparam logic [4:0] S_DVS  = 5'd11;
    localparam logic [4:0] S_DVW  = 5'd12;
    localparam logic [4:0] S_M2   = 5'd13;
    localparam logic [4:0] S_M2W  = 5'd14;
    localparam logic [4:0] S_M3   = 5'd15;
    localparam logic [4:0] S_M3W  = 5'd16;
    localparam logic [4:0] S_WR   = 5'd17;
    localparam logic [4:0] S_B0   = 5'd18;
    localparam logic [4:0] S_B1   = 5'd19;
    localparam logic [4:0] S_B2   = 5'd20;
    localparam logic [4:0] S_B3   = 5'd21;
    localparam logic [4:0] S_BM   = 5'd22;
    localparam logic [4:0] S_BMW  = 5'd23;
    localparam logic [4:0] S_BU   = 5'd24;
    localparam logic [4:0] S_DONE = 5'd25;

    localparam logic [1:0] PH_H = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_E = 2'd2;

    // Configuration.
    logic [fdtd_pkg::COURANT_W-1:0]       courant_reg;
    logic [fdtd_pkg::NCELL_W-1:0]         ncell_reg;
    logic [fdtd_pkg::PCELL_W-1:0]         pcell_reg;
    logic                                 mode_reg;
    logic signed [fdtd_pkg::BLOCH_W-1:0]  cos_reg;
    logic signed [fdtd_pkg::BLOCH_W-1:0]  sin_reg;
    logic [fdtd_pkg::NCELL_W-1:0]         ncell_wr;
    logic [fdtd_pkg::PCELL_W-1:0]         pcell_wr;

    // Memories.
    logic signed [DW-1:0] e_re_mem [DEPTH];
    logic signed [DW-1:0] e_im_mem [DEPTH];
    logic signed [DW-1:0] h_re_mem [DEPTH];
    logic signed [DW-1:0] h_im_mem [DEPTH];
    logic signed [DW-1:0] inv_mem  [DEPTH];
    logic signed [DW-1:0] hp_mem   [fdtd_pkg::MAX_PML];
    logic signed [DW-1:0] ep_mem   [fdtd_pkg::MAX_PML];
    logic signed [DW-1:0] e_re_q, e_im_q, h_re_q, h_im_q, inv_q, hp_q, ep_q;

    logic [CW-1:0]        rd_addr;
    logic [CW-1:0]        wr_addr;
    logic                 we_e_re, we_e_im, we_h_re, we_h_im, we_inv, we_hp, we_ep;
    logic signed [DW-1:0] wd_re, wd_im;
    logic [PW-1:0]        prof_addr;

    // Sequencer.
    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] clr_cnt_reg;
    logic [1:0]    phase_reg;
    logic          cmp_reg;
    logic [CW-1:0] z_reg;
    logic [1:0]    bj_reg;
    logic [2:0]    bk_reg;
    logic          sat_reg;
    logic [CW-1:0] io_idx_reg;
    logic          io_h_reg;

    // Datapath registers.
    logic signed [DW-1:0]   f_reg, x1_reg, t_reg, inv_reg, cz_reg, damp_reg, k_reg, inv0_reg;
    logic signed [DW:0]     diff_reg;
    logic                   eps_reg, pml_reg, den_neg_reg;
    logic signed [DW-1:0]   bh_reg [4];
    logic signed [DW-1:0]   be_reg [4];
    logic signed [DW-1:0]   bm_reg [4];
    logic signed [fdtd_pkg::PROD_W-1:0] prod_reg, acc_reg;
    logic signed [fdtd_pkg::OP_W-1:0]   mul_a, mul_b;

    // Output register.
    logic           m_valid_reg;
    logic [DW-1:0]  m_re_reg, m_im_reg;
    logic [1:0]     m_st_reg;
    logic           out_free;

    // Input fields.
    logic                 accept;
    logic [2:0]           in_func;
    logic [CW-1:0]        in_idx;
    logic signed [DW-1:0] in_re, in_im;
    logic                 grid_ok, prof_ok;

    assign in_func = s_tuser;
    assign in_idx  = s_tdata[10:0];
    assign in_re   = s_tdata[42:11];
    assign in_im   = s_tdata[74:43];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign grid_ok  = in_idx <= ncell_reg;
    assign prof_ok  = in_idx < CW'(fdtd_pkg::MAX_PML);

    // Grid geometry of the current point.
    logic [fdtd_pkg::PCELL_W-1:0] p_eff;
    logic                         h_ph, lo_pml, hi_pml, last_z;
    logic [CW-1:0]                lo_idx, hi_idx;

    assign p_eff  = mode_reg ? '0 : pcell_reg;
    assign h_ph   = phase_reg == PH_H;
    assign lo_pml = h_ph ? (z_reg < CW'(p_eff)) : (z_reg <= CW'(p_eff));
    assign hi_pml = ({1'b0, z_reg} + (CW+1)'(p_eff)) >= {1'b0, ncell_reg};
    assign lo_idx = h_ph ? z_reg : z_reg - 1'b1;
    assign hi_idx = ncell_reg - 1'b1 - z_reg;
    assign prof_addr = lo_pml ? lo_idx[PW-1:0] : hi_idx[PW-1:0];
    assign last_z = (z_reg + 1'b1) == ncell_reg;

    // Arithmetic.
    fdtd_pkg::rs_t        rs_prod, rs_acc, rs_wr;
    logic signed [fdtd_pkg::SUM_W-1:0] wsum;
    logic signed [fdtd_pkg::OP_W-1:0]  den;
    logic [fdtd_pkg::OP_W-1:0]         den_abs;
    fdtd_pkg::div_req_t                div_req;
    logic                              div_done;
    logic [fdtd_pkg::DVD_W-1:0]        div_q;
    logic                              q_hi;
    logic [DW-1:0]                     k_calc;
    logic                              k_sat;

    assign rs_prod = fdtd_pkg::rnd_sat(prod_reg);
    assign rs_acc  = fdtd_pkg::rnd_sat(acc_reg + prod_reg);
    assign wsum    = fdtd_pkg::SUM_W'(f_reg) - fdtd_pkg::SUM_W'(t_reg)
                   - fdtd_pkg::SUM_W'(damp_reg);
    assign rs_wr   = fdtd_pkg::sat_to32(fdtd_pkg::PROD_W'(wsum));

    assign den     = fdtd_pkg::DEN_BASE + fdtd_pkg::OP_W'(cz_reg);
    assign den_abs = den[fdtd_pkg::OP_W-1] ? -den : den;
    assign div_req.start    = (state_reg == S_DVS) && (den != '0);
    assign div_req.divisor  = den_abs[fdtd_pkg::DVS_W-1:0];
    assign div_req.dividend = fdtd_pkg::NUM_BASE
                            + fdtd_pkg::DVD_W'(den_abs[fdtd_pkg::OP_W-1:1]);

    fdtd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_hi = |div_q[fdtd_pkg::DVD_W-1:DW];
    always_comb begin
        if (den_neg_reg) begin
            k_sat  = q_hi || (div_q[DW-1] && |div_q[DW-2:0]);
            k_calc = k_sat ? fdtd_pkg::K_MIN : -div_q[DW-1:0];
        end else begin
            k_sat  = q_hi || div_q[DW-1];
            k_calc = k_sat ? fdtd_pkg::K_MAX : div_q[DW-1:0];
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M0: begin
                mul_a = fdtd_pkg::OP_W'(courant_reg);
                mul_b = fdtd_pkg::OP_W'(diff_reg);
            end
            S_M1: begin
                mul_a = fdtd_pkg::OP_W'(t_reg);
                mul_b = fdtd_pkg::OP_W'(inv_reg);
            end
            S_M2: begin
                mul_a = fdtd_pkg::OP_W'(t_reg);
                mul_b = fdtd_pkg::OP_W'(k_reg);
            end
            S_M3: begin
                mul_a = fdtd_pkg::OP_W'(cz_reg);
                mul_b = fdtd_pkg::OP_W'(f_reg);
            end
            S_BM: begin
                // Pairs summed two at a time give conj(B)*H[nz-1] and B*H[0].
                mul_a = bk_reg[0] ? fdtd_pkg::OP_W'(sin_reg) : fdtd_pkg::OP_W'(cos_reg);
                unique case (bk_reg)
                    3'd0: mul_b = fdtd_pkg::OP_W'(bh_reg[2]);
                    3'd1: mul_b = fdtd_pkg::OP_W'(bh_reg[3]);
                    3'd2: mul_b = fdtd_pkg::OP_W'(bh_reg[3]);
                    3'd3: mul_b = -fdtd_pkg::OP_W'(bh_reg[2]);
                    3'd4: mul_b = fdtd_pkg::OP_W'(bh_reg[0]);
                    3'd5: mul_b = -fdtd_pkg::OP_W'(bh_reg[1]);
                    3'd6: mul_b = fdtd_pkg::OP_W'(bh_reg[1]);
                    default: mul_b = fdtd_pkg::OP_W'(bh_reg[0]);
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Memory address and write selection.
    always_comb begin
        unique case (state_reg)
            S_IORD:  rd_addr = io_idx_reg;
            S_RD0:   rd_addr = h_ph ? z_reg + 1'b1 : z_reg;
            S_RD1:   rd_addr = h_ph ? z_reg : z_reg - 1'b1;
            S_B1:    rd_addr = ncell_reg - 1'b1;
            S_B2:    rd_addr = ncell_reg;
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        we_e_re = 1'b0;
        we_e_im = 1'b0;
        we_h_re = 1'b0;
        we_h_im = 1'b0;
        we_inv  = 1'b0;
        we_hp   = 1'b0;
        we_ep   = 1'b0;
        wr_addr = in_idx;
        wd_re   = in_re;
        wd_im   = in_im;
        if (state_reg == S_CLR) begin
            wr_addr = clr_cnt_reg;
            wd_re   = '0;
            wd_im   = '0;
            we_e_re = 1'b1;
            we_e_im = 1'b1;
            we_h_re = 1'b1;
            we_h_im = 1'b1;
        end else if (state_reg == S_WR) begin
            wd_re = rs_wr.val;
            wd_im = rs_wr.val;
            if (phase_reg == PH_B) begin
                wr_addr = bj_reg[1] ? ncell_reg : '0;
                we_e_re = !bj_reg[0];
                we_e_im = bj_reg[0];
            end else begin
                wr_addr = z_reg;
                we_e_re = !h_ph && !cmp_reg;
                we_e_im = !h_ph && cmp_reg;
                we_h_re = h_ph && !cmp_reg;
                we_h_im = h_ph && cmp_reg;
            end
        end else if (accept) begin
            we_e_re = (in_func == fdtd_pkg::FN_WE) && grid_ok;
            we_e_im = (in_func == fdtd_pkg::FN_WE) && grid_ok;
            we_h_re = (in_func == fdtd_pkg::FN_WH) && grid_ok;
            we_h_im = (in_func == fdtd_pkg::FN_WH) && grid_ok;
            we_inv  = (in_func == fdtd_pkg::FN_WINV) && grid_ok;
            we_hp   = (in_func == fdtd_pkg::FN_WHP) && prof_ok;
            we_ep   = (in_func == fdtd_pkg::FN_WEP) && prof_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_e_re) e_re_mem[wr_addr] <= wd_re;
        if (we_e_im) e_im_mem[wr_addr] <= wd_im;
        if (we_h_re) h_re_mem[wr_addr] <= wd_re;
        if (we_h_im) h_im_mem[wr_addr] <= wd_im;
        if (we_inv)  inv_mem[wr_addr]  <= wd_re;
        if (we_hp)   hp_mem[in_idx[PW-1:0]] <= wd_re;
        if (we_ep)   ep_mem[in_idx[PW-1:0]] <= wd_re;
        e_re_q <= e_re_mem[rd_addr];
        e_im_q <= e_im_mem[rd_addr];
        h_re_q <= h_re_mem[rd_addr];
        h_im_q <= h_im_mem[rd_addr];
        inv_q  <= inv_mem[rd_addr];
        hp_q   <= hp_mem[prof_addr];
        ep_q   <= ep_mem[prof_addr];
    end

    logic signed [DW-1:0] e_c_q, h_c_q;
    assign e_c_q = cmp_reg ? e_im_q : e_re_q;
    assign h_c_q = cmp_reg ? h_im_q : h_re_q;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == CW'(fdtd_pkg::MAX_CELLS)) state_next = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (in_func == fdtd_pkg::FN_STEP) begin
                        state_next = S_RD0;
                    end else if ((in_func == fdtd_pkg::FN_RE || in_func == fdtd_pkg::FN_RH)
                                 && grid_ok) begin
                        state_next = S_IORD;
                    end
                end
            end
            S_IORD: state_next = S_IOCP;
            S_IOCP: state_next = S_IDLE;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_M0;
            S_M0:   state_next = S_M0W;
            S_M0W:  state_next = eps_reg ? S_M1 : (pml_reg ? S_DVS : S_WR);
            S_M1:   state_next = S_M1W;
            S_M1W:  state_next = pml_reg ? S_DVS : S_WR;
            S_DVS:  state_next = (den == '0) ? S_M2 : S_DVW;
            S_DVW:  if (div_done) state_next = S_M2;
            S_M2:   state_next = S_M2W;
            S_M2W:  state_next = S_M3;
            S_M3:   state_next = S_M3W;
            S_M3W:  state_next = S_WR;
            S_WR: begin
                priority if (phase_reg == PH_B) begin
                    state_next = (bj_reg == 2'd3) ? S_RD0 : S_BU;
                end else if (h_ph && last_z && cmp_reg && mode_reg) begin
                    state_next = S_B0;
                end else if (!h_ph && last_z && cmp_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_RD0;
                end
            end
            S_B0:   state_next = S_B1;
            S_B1:   state_next = S_B2;
            S_B2:   state_next = S_B3;
            S_B3:   state_next = S_BM;
            S_BM:   state_next = S_BMW;
            S_BMW:  state_next = (bk_reg == 3'd7) ? S_BU : S_BM;
            S_BU:   state_next = S_M0;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign ncell_wr = (cfg_wdata[10:0] < 11'd2) ? 11'd2 :
                      (cfg_wdata[10:0] > 11'(fdtd_pkg::MAX_CELLS)) ?
                      11'(fdtd_pkg::MAX_CELLS) : cfg_wdata[10:0];
    assign pcell_wr = (cfg_wdata[6:0] > 7'(fdtd_pkg::MAX_PML)) ?
                      7'(fdtd_pkg::MAX_PML) : cfg_wdata[6:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            courant_reg <= 25'd8388608;
            ncell_reg   <= 11'(fdtd_pkg::MAX_CELLS);
            pcell_reg   <= '0;
            mode_reg    <= 1'b0;
            cos_reg     <= 26'sd16777216;
            sin_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wen) begin
                unique case (cfg_addr)
                    fdtd_pkg::CFG_COURANT: courant_reg <= cfg_wdata[24:0];
                    fdtd_pkg::CFG_NCELL:   ncell_reg   <= ncell_wr;
                    fdtd_pkg::CFG_PML:     pcell_reg   <= pcell_wr;
                    fdtd_pkg::CFG_MODE:    mode_reg    <= cfg_wdata[0];
                    fdtd_pkg::CFG_COS:     cos_reg     <= cfg_wdata;
                    fdtd_pkg::CFG_SIN:     sin_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tready) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR: clr_cnt_reg <= clr_cnt_reg + 1'b1;
                S_IDLE: begin
                    if (accept) begin
                        io_idx_reg <= in_idx;
                        io_h_reg   <= in_func == fdtd_pkg::FN_RH;
                        sat_reg    <= 1'b0;
                        phase_reg  <= PH_H;
                        cmp_reg    <= 1'b0;
                        z_reg      <= '0;
                        if (in_func != fdtd_pkg::FN_STEP && state_next == S_IDLE) begin
                            m_valid_reg <= 1'b1;
                            m_re_reg    <= '0;
                            m_im_reg    <= '0;
                            if (in_func == fdtd_pkg::FN_WHP || in_func == fdtd_pkg::FN_WEP)
                                m_st_reg <= prof_ok ? fdtd_pkg::STAT_OK : fdtd_pkg::STAT_RANGE;
                            else
                                m_st_reg <= grid_ok ? fdtd_pkg::STAT_OK : fdtd_pkg::STAT_RANGE;
                        end
                    end
                end
                S_IOCP: begin
                    m_valid_reg <= 1'b1;
                    m_re_reg    <= io_h_reg ? h_re_q : e_re_q;
                    m_im_reg    <= io_h_reg ? h_im_q : e_im_q;
                    m_st_reg    <= fdtd_pkg::STAT_OK;
                end
                S_RD1: begin
                    if (h_ph) begin
                        x1_reg <= e_c_q;
                    end else begin
                        x1_reg  <= h_c_q;
                        f_reg   <= e_c_q;
                        inv_reg <= inv_q;
                    end
                end
                S_RD2: begin
                    if (h_ph) begin
                        f_reg    <= h_c_q;
                        diff_reg <= (DW+1)'(x1_reg) - (DW+1)'(e_c_q);
                        cz_reg   <= hp_q;
                    end else begin
                        diff_reg <= (DW+1)'(x1_reg) - (DW+1)'(h_c_q);
                        cz_reg   <= ep_q;
                    end
                    pml_reg  <= lo_pml || hi_pml;
                    eps_reg  <= !h_ph;
                    damp_reg <= '0;
                end
                S_M0W, S_M1W, S_M2W: begin
                    t_reg   <= rs_prod.val;
                    sat_reg <= sat_reg | rs_prod.sat;
                end
                S_M3W: begin
                    damp_reg <= rs_prod.val;
                    sat_reg  <= sat_reg | rs_prod.sat;
                end
                S_DVS: begin
                    den_neg_reg <= den[fdtd_pkg::OP_W-1];
                    if (den == '0) begin
                        k_reg   <= fdtd_pkg::K_MAX;
                        sat_reg <= 1'b1;
                    end
                end
                S_DVW: begin
                    if (div_done) begin
                        k_reg   <= k_calc;
                        sat_reg <= sat_reg | k_sat;
                    end
                end
                S_WR: begin
                    sat_reg <= sat_reg | rs_wr.sat;
                    if (phase_reg == PH_B) begin
                        bj_reg <= bj_reg + 1'b1;
                        if (bj_reg == 2'd3) begin
                            phase_reg <= PH_E;
                            cmp_reg   <= 1'b0;
                            z_reg     <= CW'(1);
                        end
                    end else if (last_z) begin
                        if (!cmp_reg) begin
                            cmp_reg <= 1'b1;
                            z_reg   <= h_ph ? '0 : CW'(1);
                        end else if (h_ph) begin
                            cmp_reg <= 1'b0;
                            bj_reg  <= '0;
                            z_reg   <= CW'(1);
                            phase_reg <= mode_reg ? PH_B : PH_E;
                        end
                    end else begin
                        z_reg <= z_reg + 1'b1;
                    end
                end
                S_B1: begin
                    bh_reg[0] <= h_re_q;
                    bh_reg[1] <= h_im_q;
                    be_reg[0] <= e_re_q;
                    be_reg[1] <= e_im_q;
                    inv0_reg  <= inv_q;
                end
                S_B2: begin
                    bh_reg[2] <= h_re_q;
                    bh_reg[3] <= h_im_q;
                end
                S_B3: begin
                    be_reg[2] <= e_re_q;
                    be_reg[3] <= e_im_q;
                    bk_reg    <= '0;
                end
                S_BMW: begin
                    if (!bk_reg[0]) begin
                        acc_reg <= prod_reg;
                    end else begin
                        bm_reg[bk_reg[2:1]] <= rs_acc.val;
                        sat_reg <= sat_reg | rs_acc.sat;
                    end
                    bk_reg <= bk_reg + 1'b1;
                end
                S_BU: begin
                    f_reg    <= be_reg[bj_reg];
                    eps_reg  <= 1'b1;
                    pml_reg  <= 1'b0;
                    inv_reg  <= inv0_reg;
                    damp_reg <= '0;
                    unique case (bj_reg)
                        2'd0: diff_reg <= (DW+1)'(bh_reg[0]) - (DW+1)'(bm_reg[0]);
                        2'd1: diff_reg <= (DW+1)'(bh_reg[1]) - (DW+1)'(bm_reg[1]);
                        2'd2: diff_reg <= (DW+1)'(bm_reg[2]) - (DW+1)'(bh_reg[2]);
                        default: diff_reg <= (DW+1)'(bm_reg[3]) - (DW+1)'(bh_reg[3]);
                    endcase
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_re_reg    <= '0;
                        m_im_reg    <= '0;
                        m_st_reg    <= sat_reg ? fdtd_pkg::STAT_SAT : fdtd_pkg::STAT_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_im_reg, m_re_reg};
    assign m_tuser  = m_st_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DVW)
        else $error("divider finished outside its wait state");

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while result register is blocked");

    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> (!s_tready && !m_tvalid))
        else $error("activity during clearing pass");
`endif

endmodule

@@ sim/fdtd_1d_yee_field_step_unit_test.sv @@
import fdtd_pkg::*;

typedef struct {
    logic signed [31:0] data_re;
    logic signed [31:0] data_im;
    logic [1:0]         status;
} grid_reply_t;

class field_scoreboard;
    int fails;
    int items_seen;
    int steps_seen;
    int replies_seen;
    grid_reply_t replies_due[$];

    logic [24:0] courant;
    int unsigned ncell;
    int unsigned npml;
    bit          periodic;
    longint      bcos;
    longint      bsin;
    int e_re[MAX_CELLS+1];
    int e_im[MAX_CELLS+1];
    int h_re[MAX_CELLS+1];
    int h_im[MAX_CELLS+1];
    int inv_eps[MAX_CELLS+1];
    int h_sigma[MAX_PML];
    int e_sigma[MAX_PML];
    bit clipped;

    function new();
        courant  = 25'd8388608;
        ncell    = 1024;
        npml     = 0;
        periodic = 0;
        bcos     = 16777216;
        bsin     = 0;
        foreach (e_re[i]) begin
            e_re[i] = 0; e_im[i] = 0; h_re[i] = 0; h_im[i] = 0; inv_eps[i] = 0;
        end
        foreach (h_sigma[i]) begin
            h_sigma[i] = 0; e_sigma[i] = 0;
        end
    endfunction

    function int clip32(longint v);
        if (v > 64'sd2147483647) begin
            clipped = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // Round half up: an arithmetic shift of a 64-bit value is a floor.
    function longint round_q(longint v);
        return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function int mul_q(int a, int b);
        return clip32(round_q(longint'(a) * longint'(b)));
    endfunction

    function int absorb_gain(int cz);
        longint den;
        longint mag;
        longint q;
        den = (64'sd1 <<< (FRAC_BITS + 1)) + longint'(cz);
        if (den == 0) begin
            clipped = 1;
            return 32'sh7fffffff;
        end
        mag = (den < 0) ? -den : den;
        q = ((64'sd1 <<< (2 * FRAC_BITS + 1)) + mag / 2) / mag;
        return clip32((den < 0) ? -q : q);
    endfunction

    function int advance(int f, longint diff, bit scaled, int inv, bit pml, int cz);
        int t;
        int damp;
        t = clip32(round_q(longint'({39'd0, courant}) * diff));
        damp = 0;
        if (scaled)
            t = mul_q(t, inv);
        if (pml) begin
            t = mul_q(t, absorb_gain(cz));
            damp = mul_q(cz, f);
        end
        return clip32(longint'(f) - longint'(t) - longint'(damp));
    endfunction

    function void time_step();
        int unsigned p;
        bit pml;
        int cz;
        longint h0r, h0i, hnr, hni;
        int mr, mi, pr, pi;
        p = periodic ? 0 : npml;
        for (int unsigned z = 0; z < ncell; z++) begin
            pml = 0;
            cz = 0;
            if (z < p) begin
                pml = 1; cz = h_sigma[z];
            end else if (z + p >= ncell) begin
                pml = 1; cz = h_sigma[ncell-1-z];
            end
            h_re[z] = advance(h_re[z], longint'(e_re[z+1]) - e_re[z], 0, 0, pml, cz);
        end
        for (int unsigned z = 0; z < ncell; z++) begin
            pml = 0;
            cz = 0;
            if (z < p) begin
                pml = 1; cz = h_sigma[z];
            end else if (z + p >= ncell) begin
                pml = 1; cz = h_sigma[ncell-1-z];
            end
            h_im[z] = advance(h_im[z], longint'(e_im[z+1]) - e_im[z], 0, 0, pml, cz);
        end
        if (periodic) begin
            h0r = h_re[0];
            h0i = h_im[0];
            hnr = h_re[ncell-1];
            hni = h_im[ncell-1];
            mr = clip32(round_q(bcos * hnr + bsin * hni));
            mi = clip32(round_q(bcos * hni - bsin * hnr));
            pr = clip32(round_q(bcos * h0r - bsin * h0i));
            pi = clip32(round_q(bcos * h0i + bsin * h0r));
            e_re[0] = advance(e_re[0], h0r - mr, 1, inv_eps[0], 0, 0);
            e_im[0] = advance(e_im[0], h0i - mi, 1, inv_eps[0], 0, 0);
            e_re[ncell] = advance(e_re[ncell], longint'(pr) - hnr, 1, inv_eps[0], 0, 0);
            e_im[ncell] = advance(e_im[ncell], longint'(pi) - hni, 1, inv_eps[0], 0, 0);
        end
        for (int unsigned z = 1; z < ncell; z++) begin
            pml = 0;
            cz = 0;
            if (z <= p) begin
                pml = 1; cz = e_sigma[z-1];
            end else if (z + p >= ncell) begin
                pml = 1; cz = e_sigma[ncell-1-z];
            end
            e_re[z] = advance(e_re[z], longint'(h_re[z]) - h_re[z-1], 1, inv_eps[z], pml, cz);
        end
        for (int unsigned z = 1; z < ncell; z++) begin
            pml = 0;
            cz = 0;
            if (z <= p) begin
                pml = 1; cz = e_sigma[z-1];
            end else if (z + p >= ncell) begin
                pml = 1; cz = e_sigma[ncell-1-z];
            end
            e_im[z] = advance(e_im[z], longint'(h_im[z]) - h_im[z-1], 1, inv_eps[z], pml, cz);
        end
    endfunction

    function void set_register(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] data);
        int unsigned v;
        case (addr)
            CFG_COURANT: courant = data[24:0];
            CFG_NCELL: begin
                v = data[10:0];
                ncell = (v < 2) ? 2 : (v > MAX_CELLS) ? MAX_CELLS : v;
            end
            CFG_PML: begin
                v = data[6:0];
                npml = (v > MAX_PML) ? MAX_PML : v;
            end
            CFG_MODE: periodic = data[0];
            CFG_COS:  bcos = longint'(signed'(data[25:0]));
            CFG_SIN:  bsin = longint'(signed'(data[25:0]));
            default: ;
        endcase
    endfunction

    function void note_item(logic [2:0] func, logic [10:0] idx, int vr, int vi);
        grid_reply_t r;
        bit grid_ok;
        bit prof_ok;
        grid_ok = idx <= ncell;
        prof_ok = idx < MAX_PML;
        r.data_re = 0;
        r.data_im = 0;
        r.status = STAT_OK;
        items_seen++;
        case (func)
            FN_WE: if (grid_ok) begin
                e_re[idx] = vr; e_im[idx] = vi;
            end else r.status = STAT_RANGE;
            FN_WH: if (grid_ok) begin
                h_re[idx] = vr; h_im[idx] = vi;
            end else r.status = STAT_RANGE;
            FN_WINV: if (grid_ok) inv_eps[idx] = vr; else r.status = STAT_RANGE;
            FN_WHP:  if (prof_ok) h_sigma[idx] = vr; else r.status = STAT_RANGE;
            FN_WEP:  if (prof_ok) e_sigma[idx] = vr; else r.status = STAT_RANGE;
            FN_STEP: begin
                steps_seen++;
                clipped = 0;
                time_step();
                if (clipped) r.status = STAT_SAT;
            end
            FN_RE: if (grid_ok) begin
                r.data_re = e_re[idx]; r.data_im = e_im[idx];
            end else r.status = STAT_RANGE;
            default: if (grid_ok) begin
                r.data_re = h_re[idx]; r.data_im = h_im[idx];
            end else r.status = STAT_RANGE;
        endcase
        replies_due.push_back(r);
    endfunction

    function void check_reply(logic [31:0] dr, logic [31:0] di, logic [1:0] st);
        grid_reply_t r;
        replies_seen++;
        if (replies_due.size() == 0) begin
            $error("result beat with no item outstanding");
            fails++;
            return;
        end
        r = replies_due.pop_front();
        if (dr !== r.data_re) begin
            $error("data_re: expected %h, got %h", r.data_re, dr);
            fails++;
        end
        if (di !== r.data_im) begin
            $error("data_im: expected %h, got %h", r.data_im, di);
            fails++;
        end
        if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            fails++;
        end
    endfunction
endclass

module fdtd_1d_yee_field_step_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [79:0]       s_tdata = '0;  // index, value_re, value_im, zero pad
    logic [2:0]        s_tuser = '0;  // func
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [63:0]       m_tdata;       // data_re, data_im
    logic [1:0]        m_tuser;       // status
    logic              cfg_wen = 0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    field_scoreboard sb = new();
    int  stall_cycles = 0;
    bit  calm = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    fdtd_1d_yee_field_step_unit u_top (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_left = HOLD_CYCLES;
            m_tready <= 0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 14);
        end
    end

    always @(posedge aclk) begin
        bit moved;
        moved = 0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_reply(m_tdata[31:0], m_tdata[63:32], m_tuser);
                moved = 1;
            end
            if (s_tvalid && s_tready) begin
                sb.note_item(s_tuser, s_tdata[10:0], s_tdata[42:11], s_tdata[74:43]);
                moved = 1;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    task automatic send_item(logic [2:0] func, logic [10:0] idx, int vr, int vi);
        while (!calm && $urandom_range(99) < 14) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= {16'd0, vi, vr, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] data);
        cfg_wen   <= 1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        sb.set_register(addr, data);
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    function automatic int modest();
        return int'($urandom_range(33554432)) - 16777216;
    endfunction

    // Reconfigures, then loads every coefficient a step can read.
    task automatic setup(int cr, int nz, int p, int mode, int bc, int bs, bit null_den);
        drain();
        write_reg(CFG_COURANT, CFG_W'(cr));
        write_reg(CFG_NCELL, CFG_W'(nz));
        write_reg(CFG_PML, CFG_W'(p));
        write_reg(CFG_MODE, CFG_W'(mode));
        write_reg(CFG_COS, CFG_W'(bc));
        write_reg(CFG_SIN, CFG_W'(bs));
        for (int i = 0; i <= sb.ncell; i++)
            send_item(FN_WINV, 11'(i), int'($urandom_range(33554432)), 0);
        // Only profile entries inside the grid are read, and none in periodic mode.
        for (int i = 0; i < sb.npml && i < sb.ncell && !sb.periodic; i++) begin
            send_item(FN_WHP, 11'(i), int'($urandom_range(16777216)), 0);
            send_item(FN_WEP, 11'(i), int'($urandom_range(16777216)), 0);
        end
        // A conductivity of -2 makes the absorbing denominator vanish.
        if (null_den && sb.npml > 0) begin
            send_item(FN_WHP, 0, -33554432, 0);
            send_item(FN_WEP, 0, -33554432, 0);
        end
    endtask

    task automatic random_items(int count);
        logic [2:0]  func;
        logic [10:0] idx;
        int          vr, vi;
        repeat (count) begin
            func = 3'($urandom_range(7));
            if ($urandom_range(99) < 10)
                func = FN_STEP;
            if ($urandom_range(99) < 15)
                idx = 11'($urandom());
            else
                idx = 11'($urandom_range(sb.ncell));
            if ($urandom_range(1)) begin
                vr = $urandom();
                vi = $urandom();
            end else begin
                vr = modest();
                vi = modest();
            end
            if (func == FN_WHP || func == FN_WEP)
                vr = $urandom_range(3) == 0 ? int'($urandom()) : $urandom_range(16777216);
            send_item(func, idx, vr, vi);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        send_item(FN_WE, 0, 32'sh7fffffff, 32'sh80000000);
        send_item(FN_WE, 1024, 32'sh80000000, 32'sh7fffffff);
        send_item(FN_WH, 0, -1, 0);
        send_item(FN_WH, 1024, 0, -1);
        send_item(FN_RE, 0, 0, 0);
        send_item(FN_RE, 1024, 0, 0);
        send_item(FN_RH, 0, 0, 0);
        send_item(FN_RH, 1024, 0, 0);
        send_item(FN_RE, 512, 0, 0);
        send_item(FN_WE, 1025, 1, 1);
        send_item(FN_WH, 2047, 1, 1);
        send_item(FN_WINV, 1025, 1, 0);
        send_item(FN_WINV, 0, 16777216, 0);
        send_item(FN_RE, 2047, 0, 0);
        send_item(FN_RH, 1025, 0, 0);
        send_item(FN_WHP, 63, 16777216, 0);
        send_item(FN_WHP, 64, 1, 0);
        send_item(FN_WEP, 63, 16777216, 0);
        send_item(FN_WEP, 2047, 1, 0);

        // Two cells, PML clipped to the maximum so both ends overlap everywhere.
        setup(16777216, 0, 127, 0, -16777216, 16777216, 1);
        send_item(FN_WE, 1, 32'sh7fffffff, 32'sh80000000);
        send_item(FN_STEP, 2047, 0, 0);
        random_items(12);

        // A layer thicker than the grid, so every point is absorbing.
        setup(0, 6, 64, 0, 16777216, -16777216, 0);
        send_item(FN_WE, 3, 16777216, -16777216);
        send_item(FN_STEP, 0, 0, 0);
        send_item(FN_RE, 3, 0, 0);
        setup(16777216, 5, 2, 0, 16777216, 0, 0);
        send_item(FN_WE, 1, 16777216, -16777216);
        send_item(FN_STEP, 0, 0, 0);
        send_item(FN_RH, 0, 0, 0);

        // Periodic ends; the PML setting must be ignored.
        setup($urandom_range(16777216), $urandom_range(8, 4), $urandom_range(8), 1,
              modest(), modest(), 0);
        calm = 1;
        random_items(16);
        calm = 0;

        // The receiver stalls while the sender keeps offering beats.
        setup($urandom(), $urandom_range(6, 3), 2, 0, $urandom(), $urandom(), 0);
        hold_req = 1;
        random_items(25);

        setup(16777216, 2, 5, 1, -16777216, 16777216, 0);
        random_items(10);

        drain();
        repeat (50) @(posedge aclk);
        $display("covered %0d items (%0d steps) and %0d result beats",
                 sb.items_seen, sb.steps_seen, sb.replies_seen);
        $display("over metal, absorbing and periodic boundaries on grids of 2 to 8 cells");
        if (sb.fails == 0 && sb.replies_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("timed out after %0d cycles without a beat", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/fdtd_pkg.sv
rtl/core/fdtd_div.sv
rtl/core/fdtd_1d_yee_field_step_unit.sv
sim/fdtd_1d_yee_field_step_unit_test.sv
